### src/sfls_pkg.sv
// ----------------------------------------------------------------------------
// sfls_pkg: shared definitions for the swing filter linear segmenter
// Default widths, register indexes, operation codes and the control and
// status bundles between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package sfls_pkg;

  // Default widths of the value and length fields
  localparam int VALUE_WIDTH_DEF  = 32;
  localparam int LENGTH_WIDTH_DEF = 14;

  // Error bound register is unsigned Q15.16 without a sign bit
  localparam int ERR_WIDTH        = 31;

  // Configuration port shape
  localparam int CFG_INDEX_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH   = 31;

  // Register reset values
  localparam int RESET_ERROR_BOUND = 65536;
  localparam int RESET_MAX_LENGTH  = 16000;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ERROR_BOUND = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_LENGTH  = 1'd1;

  // Operation codes of an input transaction
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Command from the sequencer to the divider
  typedef struct packed {
    logic start;     // latch numerator and divisor, begin a division
    logic round_up;  // 1: ceiling quotient, 0: floor quotient
  } sfls_div_cmd_t;

  // Status from the divider to the sequencer
  typedef struct packed {
    logic busy;      // iterating
    logic done;      // one-cycle pulse, quotient valid
  } sfls_div_stat_t;

endpackage

### src/sfls_if.sv
// ----------------------------------------------------------------------------
// sfls_if: streaming channels of the swing filter linear segmenter
// Sample channel (operation, sample) and segment channel (start, slope,
// length), each with valid and ready.
// ----------------------------------------------------------------------------
interface sfls_in_if #(
  parameter int VALUE_WIDTH = sfls_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [VALUE_WIDTH-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface sfls_out_if #(
  parameter int VALUE_WIDTH  = sfls_pkg::VALUE_WIDTH_DEF,
  parameter int LENGTH_WIDTH = sfls_pkg::LENGTH_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] segment_start;
  logic signed [VALUE_WIDTH-1:0] segment_slope;
  logic [LENGTH_WIDTH-1:0]       segment_length;

  modport source (output valid, output segment_start, output segment_slope,
                  output segment_length, input ready);
  modport sink   (input valid, input segment_start, input segment_slope,
                  input segment_length, output ready);
endinterface

### src/swing_filter_linear_segmenter_top.sv
// ----------------------------------------------------------------------------
// swing_filter_linear_segmenter_top: piecewise linear segmenter, top level
// Fits Q16.16 samples to line segments inside a slope cone and emits start,
// slope and length of each closed segment.
// ----------------------------------------------------------------------------
// A sample that extends an open segment has both slope bounds computed by
// one radix-2 divider that produces one quotient bit per cycle, on a
// numerator of NUM_WIDTH = max(VALUE_WIDTH, 31) + 2 bits: each division has
// a start state and a wait state, and a check state follows before the
// block returns to idle. A sample that closes the segment then passes an
// emit state (held while an earlier segment still waits at the output),
// LENGTH_WIDTH shift-and-add steps for the fitted end value, a restart
// state and a second pair of divisions with its check; when the length
// limit closes the segment, it does so before any division. The first
// sample of a segment opens it in the idle state; a flush of an open
// segment passes only the emit state.
// The block takes no new transaction while a sample is in work; a finished
// segment waits in an output register and does not hold back the next
// transaction unless a second one is due.
module swing_filter_linear_segmenter_top #(
  parameter int VALUE_WIDTH  = sfls_pkg::VALUE_WIDTH_DEF,
  parameter int LENGTH_WIDTH = sfls_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  sfls_in_if.sink                              samples,
  sfls_out_if.source                           segments,
  input  logic                                 cfg_we,
  input  logic [sfls_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [sfls_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int NUM_WIDTH =
      ((VALUE_WIDTH > sfls_pkg::ERR_WIDTH) ? VALUE_WIDTH : sfls_pkg::ERR_WIDTH) + 2;

  sfls_pkg::sfls_div_cmd_t       div_cmd;
  sfls_pkg::sfls_div_stat_t      div_stat;
  logic signed [NUM_WIDTH-1:0]   div_num;
  logic [LENGTH_WIDTH-1:0]       div_den;
  logic signed [VALUE_WIDTH-1:0] div_quo;

  // Sequencer and segment state
  sfls_ctrl #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH),
    .NUM_WIDTH    (NUM_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .segments  (segments),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .div_cmd   (div_cmd),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_stat  (div_stat),
    .div_quo   (div_quo)
  );

  // Shared bound divider
  sfls_divider #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH),
    .NUM_WIDTH    (NUM_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .cmd       (div_cmd),
    .numerator (div_num),
    .divisor   (div_den),
    .stat      (div_stat),
    .quotient  (div_quo)
  );

  // Never take a transaction while a division runs
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !samples.ready)
    else $error("transaction accepted during a division");

  // Start a division only when the divider is free
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_cmd.start |-> !div_stat.busy)
    else $error("division started while divider busy");

  // A start command always launches the divider
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    div_cmd.start |=> div_stat.busy)
    else $error("divider did not start");

  // An emitted segment covers at least one sample
  a_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    segments.valid |-> (segments.segment_length != '0))
    else $error("segment emitted with zero length");

endmodule

### src/sfls_divider.sv
// ----------------------------------------------------------------------------
// sfls_divider: iterative radix-2 divider for slope bounds
// Divides a signed numerator by a positive offset, one quotient bit per
// cycle, rounds toward minus or plus infinity and saturates to the value
// range.
// ----------------------------------------------------------------------------
module sfls_divider #(
  parameter int VALUE_WIDTH  = sfls_pkg::VALUE_WIDTH_DEF,
  parameter int LENGTH_WIDTH = sfls_pkg::LENGTH_WIDTH_DEF,
  parameter int NUM_WIDTH    = VALUE_WIDTH + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sfls_pkg::sfls_div_cmd_t       cmd,
  input  logic signed [NUM_WIDTH-1:0]   numerator,
  input  logic [LENGTH_WIDTH-1:0]       divisor,
  output sfls_pkg::sfls_div_stat_t      stat,
  output logic signed [VALUE_WIDTH-1:0] quotient
);

  localparam int CNT_WIDTH = $clog2(NUM_WIDTH);
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [NUM_WIDTH+1:0]   HI_LIM  = (NUM_WIDTH+2)'(VAL_MAX);
  localparam logic signed [NUM_WIDTH+1:0]   LO_LIM  = (NUM_WIDTH+2)'(VAL_MIN);

  logic                    busy;
  logic                    done;
  logic [CNT_WIDTH-1:0]    cnt;
  logic [NUM_WIDTH-1:0]    quo;
  logic [LENGTH_WIDTH-1:0] rem;
  logic [LENGTH_WIDTH-1:0] den;
  logic                    neg;
  logic                    round_up;

  logic [NUM_WIDTH-1:0]    num_mag;
  logic [LENGTH_WIDTH:0]   rem_shift;
  logic                    fits;
  logic [LENGTH_WIDTH:0]   rem_sub;
  logic                    inc;
  logic [NUM_WIDTH:0]      mag;
  logic signed [NUM_WIDTH+1:0] signed_q;

  // Magnitude of the numerator
  assign num_mag = numerator[NUM_WIDTH-1] ? NUM_WIDTH'(-numerator) : NUM_WIDTH'(numerator);

  // One restoring step: shift in the next dividend bit, try to subtract
  assign rem_shift = {rem, quo[NUM_WIDTH-1]};
  assign fits      = rem_shift >= {1'b0, den};
  assign rem_sub   = rem_shift - {1'b0, den};

  // Round the magnitude away from zero when the direction calls for it
  assign inc      = (rem != '0) && (neg ? !round_up : round_up);
  assign mag      = {1'b0, quo} + (NUM_WIDTH+1)'(inc);
  assign signed_q = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // Saturate to the value range
  always_comb begin
    if (signed_q > HI_LIM) begin
      quotient = VAL_MAX;
    end else if (signed_q < LO_LIM) begin
      quotient = VAL_MIN;
    end else begin
      quotient = signed_q[VALUE_WIDTH-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  // Latch operands, then iterate one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy     <= 1'b1;
        cnt      <= '0;
        quo      <= num_mag;
        rem      <= '0;
        den      <= divisor;
        neg      <= numerator[NUM_WIDTH-1];
        round_up <= cmd.round_up;
      end else if (busy) begin
        quo <= {quo[NUM_WIDTH-2:0], fits};
        rem <= fits ? rem_sub[LENGTH_WIDTH-1:0] : rem_shift[LENGTH_WIDTH-1:0];
        cnt <= cnt + CNT_WIDTH'(1);
        if (cnt == CNT_WIDTH'(NUM_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/sfls_ctrl.sv
// ----------------------------------------------------------------------------
// sfls_ctrl: segment sequencer and state of the open segment
// Holds the segment and the registers, runs the divider for both slope
// bounds, emits closed segments and computes the restart value by
// shift-and-add.
// ----------------------------------------------------------------------------
module sfls_ctrl #(
  parameter int VALUE_WIDTH  = sfls_pkg::VALUE_WIDTH_DEF,
  parameter int LENGTH_WIDTH = sfls_pkg::LENGTH_WIDTH_DEF,
  parameter int NUM_WIDTH    = VALUE_WIDTH + 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  sfls_in_if.sink                                samples,
  sfls_out_if.source                             segments,
  input  logic                                   cfg_we,
  input  logic [sfls_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [sfls_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  output sfls_pkg::sfls_div_cmd_t                div_cmd,
  output logic signed [NUM_WIDTH-1:0]            div_num,
  output logic [LENGTH_WIDTH-1:0]                div_den,
  input  sfls_pkg::sfls_div_stat_t               div_stat,
  input  logic signed [VALUE_WIDTH-1:0]          div_quo
);

  localparam int PROD_WIDTH = VALUE_WIDTH + LENGTH_WIDTH + 1;
  localparam int MCNT_WIDTH = $clog2(LENGTH_WIDTH);
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [PROD_WIDTH:0]    END_HI  = (PROD_WIDTH+1)'(VAL_MAX);
  localparam logic signed [PROD_WIDTH:0]    END_LO  = (PROD_WIDTH+1)'(VAL_MIN);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_HI,
    ST_WAIT_HI,
    ST_DIV_LO,
    ST_WAIT_LO,
    ST_CHECK,
    ST_EMIT,
    ST_MUL,
    ST_RESTART
  } state_t;

  state_t state;

  // Registers
  logic [sfls_pkg::ERR_WIDTH-1:0] error_bound;
  logic [LENGTH_WIDTH-1:0]        max_segment_length;

  // Open segment
  logic                          segment_open;
  logic signed [VALUE_WIDTH-1:0] start_value;
  logic signed [VALUE_WIDTH-1:0] slope_upper;
  logic signed [VALUE_WIDTH-1:0] slope_lower;
  logic signed [VALUE_WIDTH-1:0] current_slope;
  logic [LENGTH_WIDTH-1:0]       sample_count;

  // Work registers
  logic signed [VALUE_WIDTH-1:0] sample_hold;
  logic                          flush_hold;
  logic signed [VALUE_WIDTH-1:0] new_upper;
  logic signed [VALUE_WIDTH-1:0] new_lower;
  logic signed [PROD_WIDTH-1:0]  mcand;
  logic [LENGTH_WIDTH-1:0]       mplier;
  logic signed [PROD_WIDTH-1:0]  acc;
  logic [MCNT_WIDTH-1:0]         mcnt;

  // Output register
  logic                          seg_valid;
  logic signed [VALUE_WIDTH-1:0] seg_start;
  logic signed [VALUE_WIDTH-1:0] seg_slope;
  logic [LENGTH_WIDTH-1:0]       seg_length;

  logic signed [NUM_WIDTH-1:0]   diff;
  logic signed [NUM_WIDTH-1:0]   err_ext;
  logic signed [NUM_WIDTH-1:0]   num_hi;
  logic signed [NUM_WIDTH-1:0]   num_lo;
  logic                          length_ok;
  logic                          cone_empty;
  logic signed [VALUE_WIDTH-1:0] upper_cut;
  logic signed [VALUE_WIDTH-1:0] lower_cut;
  logic signed [VALUE_WIDTH:0]   bound_sum;
  logic signed [PROD_WIDTH:0]    end_sum;
  logic signed [VALUE_WIDTH-1:0] end_value;
  logic                          slot_free;
  logic                          emit_now;

  // Bound numerators: sample minus start, plus or minus the error bound
  assign diff    = NUM_WIDTH'(sample_hold) - NUM_WIDTH'(start_value);
  assign err_ext = $signed(NUM_WIDTH'(error_bound));
  assign num_hi  = diff + err_ext;
  assign num_lo  = diff - err_ext;

  // Divider command follows the sequencer state
  assign div_cmd.start    = (state == ST_DIV_HI) || (state == ST_DIV_LO);
  assign div_cmd.round_up = (state == ST_DIV_LO);
  assign div_num          = (state == ST_DIV_LO) ? num_lo : num_hi;
  assign div_den          = sample_count;

  // Close the segment once its count exceeds the length limit or fills the field
  assign length_ok = (sample_count <= max_segment_length) && (sample_count != '1);

  // Narrowed cone and its midpoint
  assign cone_empty = (new_upper < slope_lower) || (new_lower > slope_upper);
  assign upper_cut  = (new_upper < slope_upper) ? new_upper : slope_upper;
  assign lower_cut  = (new_lower > slope_lower) ? new_lower : slope_lower;
  assign bound_sum  = (VALUE_WIDTH+1)'(upper_cut) + (VALUE_WIDTH+1)'(lower_cut);

  // Fitted end value, saturated
  assign end_sum = (PROD_WIDTH+1)'(start_value) + (PROD_WIDTH+1)'(acc);
  always_comb begin
    if (end_sum > END_HI) begin
      end_value = VAL_MAX;
    end else if (end_sum < END_LO) begin
      end_value = VAL_MIN;
    end else begin
      end_value = end_sum[VALUE_WIDTH-1:0];
    end
  end

  assign slot_free = !seg_valid || segments.ready;
  assign emit_now  = (state == ST_EMIT) && slot_free;

  assign samples.ready           = (state == ST_IDLE);
  assign segments.valid          = seg_valid;
  assign segments.segment_start  = seg_start;
  assign segments.segment_slope  = seg_slope;
  assign segments.segment_length = seg_length;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      error_bound        <= sfls_pkg::ERR_WIDTH'(sfls_pkg::RESET_ERROR_BOUND);
      max_segment_length <= LENGTH_WIDTH'(sfls_pkg::RESET_MAX_LENGTH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfls_pkg::REG_ERROR_BOUND: error_bound <= cfg_data[sfls_pkg::ERR_WIDTH-1:0];
        sfls_pkg::REG_MAX_LENGTH:  max_segment_length <= cfg_data[LENGTH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, segment state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      seg_valid     <= 1'b0;
      segment_open  <= 1'b0;
      start_value   <= '0;
      slope_upper   <= VAL_MAX;
      slope_lower   <= VAL_MIN;
      current_slope <= '0;
      sample_count  <= '0;
    end else begin
      // Drop the result once the sink takes it, unless a new one loads
      if (segments.ready && !emit_now) begin
        seg_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            sample_hold <= samples.sample;
            flush_hold  <= (samples.operation == sfls_pkg::OP_FLUSH);
            if (samples.operation == sfls_pkg::OP_FLUSH) begin
              if (segment_open) begin
                state <= ST_EMIT;
              end
            end else if (!segment_open) begin
              // Open a segment at this sample
              segment_open  <= 1'b1;
              start_value   <= samples.sample;
              slope_upper   <= VAL_MAX;
              slope_lower   <= VAL_MIN;
              current_slope <= '0;
              sample_count  <= LENGTH_WIDTH'(1);
            end else if (length_ok) begin
              state <= ST_DIV_HI;
            end else begin
              state <= ST_EMIT;
            end
          end
        end

        ST_DIV_HI: begin
          state <= ST_WAIT_HI;
        end

        ST_WAIT_HI: begin
          if (div_stat.done) begin
            new_upper <= div_quo;
            state     <= ST_DIV_LO;
          end
        end

        ST_DIV_LO: begin
          state <= ST_WAIT_LO;
        end

        ST_WAIT_LO: begin
          if (div_stat.done) begin
            new_lower <= div_quo;
            state     <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          if (cone_empty) begin
            state <= ST_EMIT;
          end else begin
            // Commit the narrowed cone and advance the offset
            slope_upper   <= upper_cut;
            slope_lower   <= lower_cut;
            current_slope <= bound_sum[VALUE_WIDTH:1];
            sample_count  <= sample_count + LENGTH_WIDTH'(1);
            state         <= ST_IDLE;
          end
        end

        ST_EMIT: begin
          if (slot_free) begin
            seg_valid  <= 1'b1;
            seg_start  <= start_value;
            seg_slope  <= current_slope;
            seg_length <= sample_count;
            if (flush_hold) begin
              segment_open  <= 1'b0;
              start_value   <= '0;
              slope_upper   <= VAL_MAX;
              slope_lower   <= VAL_MIN;
              current_slope <= '0;
              sample_count  <= '0;
              state         <= ST_IDLE;
            end else begin
              // Set up slope times (count - 1)
              mcand <= PROD_WIDTH'(current_slope);
              mplier <= sample_count - LENGTH_WIDTH'(1);
              acc   <= '0;
              mcnt  <= '0;
              state <= ST_MUL;
            end
          end
        end

        ST_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          mcnt   <= mcnt + MCNT_WIDTH'(1);
          if (mcnt == MCNT_WIDTH'(LENGTH_WIDTH - 1)) begin
            state <= ST_RESTART;
          end
        end

        ST_RESTART: begin
          // New segment from the fitted end; the held sample enters at offset 1
          start_value   <= end_value;
          slope_upper   <= VAL_MAX;
          slope_lower   <= VAL_MIN;
          current_slope <= '0;
          sample_count  <= LENGTH_WIDTH'(1);
          state         <= ST_DIV_HI;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/sv/tb_swing_filter_linear_segmenter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swing_filter_linear_segmenter_top: regression of the linear segmenter
// Drives sample and flush transactions under random idling on both channels,
// predicts every closed segment with a fixed-point cone fit of its own and
// compares start, slope and length of each segment in order of arrival.
// ----------------------------------------------------------------------------
module tb_swing_filter_linear_segmenter_top;

  localparam int VW              = sfls_pkg::VALUE_WIDTH_DEF;
  localparam int LW              = sfls_pkg::LENGTH_WIDTH_DEF;
  localparam int EW              = sfls_pkg::ERR_WIDTH;
  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 9;
  localparam int MAX_GAP         = 9;
  localparam int SETTLE_CYCLES   = 200;
  localparam int HOLD_OFF_CYCLES = 2500;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int PHASE_ITEMS     = 250;
  localparam int MAX_PRINTED     = 40;

  localparam longint VALUE_MAX = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VALUE_MIN = -(longint'(1) <<< (VW - 1));
  localparam logic [EW-1:0] ERROR_BOUND_MAX = '1;
  localparam logic [LW-1:0] LENGTH_FULL     = '1;
  localparam logic [EW-1:0] ERROR_BOUND_RST = EW'(sfls_pkg::RESET_ERROR_BOUND);
  localparam logic [LW-1:0] LENGTH_RST      = LW'(sfls_pkg::RESET_MAX_LENGTH);

  typedef struct packed {
    logic signed [VW-1:0] seg_start;
    logic signed [VW-1:0] seg_slope;
    logic [LW-1:0]        seg_length;
  } segment_t;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 cfg_we;
  logic [sfls_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [sfls_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

  sfls_in_if  #(.VALUE_WIDTH(VW))                    sample_bus ();
  sfls_out_if #(.VALUE_WIDTH(VW), .LENGTH_WIDTH(LW)) segment_bus ();

  swing_filter_linear_segmenter_top #(
    .VALUE_WIDTH (VW),
    .LENGTH_WIDTH(LW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_bus),
    .segments (segment_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Fit state and register copies of the predictor
  bit                   fit_open;
  logic signed [VW-1:0] fit_start;
  logic signed [VW-1:0] fit_upper;
  logic signed [VW-1:0] fit_lower;
  logic signed [VW-1:0] fit_slope;
  logic [LW-1:0]        fit_count;
  logic [EW-1:0]        err_bound;
  logic [LW-1:0]        len_limit;

  segment_t pending_segments[$];

  int error_count      = 0;
  int items_accepted   = 0;
  int segments_checked = 0;
  int settings_used    = 0;
  int cycle_count      = 0;
  bit steady           = 1'b0;
  int hold_request     = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint clamp_value(longint v);
    if (v > VALUE_MAX) return VALUE_MAX;
    if (v < VALUE_MIN) return VALUE_MIN;
    return v;
  endfunction

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint div_ceil(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n > 0) q++;
    return q;
  endfunction

  function automatic void clear_fit();
    fit_open  = 1'b0;
    fit_start = '0;
    fit_upper = VW'(VALUE_MAX);
    fit_lower = VW'(VALUE_MIN);
    fit_slope = '0;
    fit_count = '0;
  endfunction

  // Narrow the slope cone with sample y at offset x; 0 when the cone empties
  function automatic bit narrow_cone(longint y, longint x);
    longint diff;
    longint nu;
    longint nl;
    diff = y - longint'(fit_start);
    nu = clamp_value(div_floor(diff + longint'(err_bound), x));
    nl = clamp_value(div_ceil(diff - longint'(err_bound), x));
    if (nu < longint'(fit_lower) || nl > longint'(fit_upper)) return 1'b0;
    if (nu < longint'(fit_upper)) fit_upper = VW'(nu);
    if (nl > longint'(fit_lower)) fit_lower = VW'(nl);
    fit_slope = VW'(div_floor(longint'(fit_upper) + longint'(fit_lower), 2));
    return 1'b1;
  endfunction

  // Advance the fit by one transaction; 1 when a segment closes
  function automatic bit fit_item(input logic op, input logic signed [VW-1:0] value,
                                  output segment_t seg);
    longint fit_end;
    seg = '{seg_start: fit_start, seg_slope: fit_slope, seg_length: fit_count};
    if (op == sfls_pkg::OP_FLUSH) begin
      if (!fit_open) return 1'b0;
      clear_fit();
      return 1'b1;
    end
    if (!fit_open) begin
      clear_fit();
      fit_open  = 1'b1;
      fit_start = value;
      fit_count = LW'(1);
      return 1'b0;
    end
    if (fit_count <= len_limit && fit_count < LENGTH_FULL &&
        narrow_cone(longint'(value), longint'(fit_count))) begin
      fit_count++;
      return 1'b0;
    end
    // Close and restart from the fitted end value
    fit_end = clamp_value(longint'(fit_start) +
                          longint'(fit_slope) * (longint'(fit_count) - 1));
    clear_fit();
    fit_open  = 1'b1;
    fit_start = VW'(fit_end);
    fit_count = LW'(1);
    void'(narrow_cone(longint'(value), 1));
    fit_count = LW'(2);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- monitors
  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    segment_t seg;
    if (!rst && sample_bus.valid && sample_bus.ready) begin
      items_accepted++;
      if (fit_item(sample_bus.operation, sample_bus.sample, seg))
        pending_segments = {pending_segments, seg};
    end
  end

  // Compare every accepted segment with the oldest prediction
  always @(posedge clk) begin
    segment_t want;
    if (!rst && segment_bus.valid && segment_bus.ready) begin
      segments_checked++;
      if (pending_segments.size() == 0) begin
        report_mismatch("segment with no prediction pending");
      end else begin
        want = pending_segments.pop_front();
        if (segment_bus.segment_start !== want.seg_start)
          report_mismatch($sformatf("segment %0d start %0d, predicted %0d", segments_checked,
                                    segment_bus.segment_start, want.seg_start));
        if (segment_bus.segment_slope !== want.seg_slope)
          report_mismatch($sformatf("segment %0d slope %0d, predicted %0d", segments_checked,
                                    segment_bus.segment_slope, want.seg_slope));
        if (segment_bus.segment_length !== want.seg_length)
          report_mismatch($sformatf("segment %0d length %0d, predicted %0d", segments_checked,
                                    segment_bus.segment_length, want.seg_length));
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d segments outstanding", cycle_count,
               pending_segments.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver
  // Pause a random number of cycles before each segment; honor a long hold-off
  initial begin : segment_receiver
    int pause;
    segment_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        pause = hold_request;
        hold_request = 0;
      end else begin
        pause = steady ? 0 : int'($urandom_range(0, MAX_GAP));
      end
      if (pause > 0) begin
        segment_bus.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      segment_bus.ready <= 1'b1;
      @(posedge clk);
      while (!segment_bus.valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- drivers
  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(logic op, logic signed [VW-1:0] value);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, MAX_GAP));
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid     <= 1'b1;
    sample_bus.operation <= op;
    sample_bus.sample    <= value;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
  endtask

  // Drop valid, drain all predicted segments and let the last sample settle
  task automatic wait_idle();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back cycles
  task automatic write_config(logic [EW-1:0] err, logic [LW-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= sfls_pkg::REG_ERROR_BOUND;
    cfg_data  <= sfls_pkg::CFG_DATA_WIDTH'(err);
    @(posedge clk);
    cfg_index <= sfls_pkg::REG_MAX_LENGTH;
    cfg_data  <= sfls_pkg::CFG_DATA_WIDTH'(limit);
    @(posedge clk);
    cfg_we    <= 1'b0;
    err_bound = err;
    len_limit = limit;
    settings_used++;
  endtask

  // Send a noisy straight line with an occasional spike
  task automatic send_line_burst(int n);
    longint base;
    longint step;
    longint amp;
    longint noise;
    longint pt;
    int     k;
    base = longint'(int'($urandom));
    step = longint'(int'($urandom)) >>> $urandom_range(6, 30);
    amp  = longint'(err_bound) >> $urandom_range(0, 3);
    for (k = 0; k < n; k++) begin
      noise = (amp == 0) ? 0 : (longint'($urandom) % (2 * amp + 1)) - amp;
      pt = base + step * k + noise;
      if ($urandom_range(0, 24) == 0) pt = longint'(int'($urandom));
      send_item(sfls_pkg::OP_SAMPLE, VW'(clamp_value(pt)));
    end
  endtask

  // Mix line bursts with raw samples and flushes
  task automatic run_random_items(int count);
    int left;
    int n;
    int pick;
    left = count;
    while (left > 0) begin
      pick = int'($urandom_range(0, 19));
      if (pick == 0) begin
        send_item(sfls_pkg::OP_FLUSH, VW'($urandom));
        left--;
      end else if (pick < 3) begin
        send_item(sfls_pkg::OP_SAMPLE, VW'($urandom));
        left--;
      end else begin
        n = int'($urandom_range(1, (left < 40) ? left : 40));
        send_line_burst(n);
        left -= n;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests
  // Empty flush, lone sample, full-scale swings, a ramp and a small step
  task automatic test_directed_basics();
    int k;
    write_config(ERROR_BOUND_RST, LENGTH_RST);
    send_item(sfls_pkg::OP_FLUSH, '0);
    send_item(sfls_pkg::OP_SAMPLE, '0);
    send_item(sfls_pkg::OP_FLUSH, '0);
    send_item(sfls_pkg::OP_SAMPLE, VW'(VALUE_MAX));
    send_item(sfls_pkg::OP_SAMPLE, VW'(VALUE_MIN));
    send_item(sfls_pkg::OP_SAMPLE, VW'(VALUE_MAX));
    send_item(sfls_pkg::OP_FLUSH, '1);
    for (k = 0; k < 4; k++) send_item(sfls_pkg::OP_SAMPLE, VW'(k * 65536));
    send_item(sfls_pkg::OP_SAMPLE, VW'(1));
    send_item(sfls_pkg::OP_FLUSH, '0);
    send_item(sfls_pkg::OP_SAMPLE, VW'(-1));
    send_item(sfls_pkg::OP_SAMPLE, VW'(1));
    send_item(sfls_pkg::OP_FLUSH, '0);
    wait_idle();
  endtask

  // Length limits of zero and one close segments early
  task automatic test_small_limits();
    int k;
    write_config(ERROR_BOUND_MAX, LW'(0));
    for (k = 1; k <= 3; k++) send_item(sfls_pkg::OP_SAMPLE, VW'(k * 100));
    send_item(sfls_pkg::OP_FLUSH, '0);
    wait_idle();
    write_config(ERROR_BOUND_MAX, LW'(1));
    for (k = 0; k < 4; k++) send_item(sfls_pkg::OP_SAMPLE, VW'(k * 7));
    send_item(sfls_pkg::OP_FLUSH, '0);
    wait_idle();
  endtask

  // Random traffic under a series of register settings, extremes included
  task automatic test_random_settings();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_config(ERROR_BOUND_RST, LENGTH_RST);
        1: write_config('0, LW'(2));
        2: write_config(ERROR_BOUND_MAX, LENGTH_RST);
        3: write_config(EW'($urandom_range(0, 1 << 22)), LW'($urandom_range(2, 48)));
        4: write_config(EW'($urandom), LENGTH_FULL);
        default: write_config(EW'($urandom_range(0, 1 << 18)), LW'($urandom_range(0, 3)));
      endcase
      run_random_items(PHASE_ITEMS);
      wait_idle();
    end
  endtask

  // No idling on either side
  task automatic test_back_to_back();
    steady = 1'b1;
    write_config(EW'($urandom_range(0, 1 << 20)), LW'($urandom_range(2, 32)));
    run_random_items(150);
    wait_idle();
    steady = 1'b0;
  endtask

  // Hold the output off while closing samples keep coming
  task automatic test_output_backpressure();
    int k;
    write_config('0, LW'(2));
    hold_request = HOLD_OFF_CYCLES;
    for (k = 0; k < 40; k++) send_item(sfls_pkg::OP_SAMPLE, VW'($urandom));
    wait_idle();
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= sfls_pkg::REG_ERROR_BOUND;
    cfg_data             <= '0;
    sample_bus.valid     <= 1'b0;
    sample_bus.operation <= sfls_pkg::OP_SAMPLE;
    sample_bus.sample    <= '0;
    err_bound = ERROR_BOUND_RST;
    len_limit = LENGTH_RST;
    clear_fit();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_basics();
    test_small_limits();
    test_random_settings();
    test_back_to_back();
    test_output_backpressure();

    $display("Ran %0d sample and flush transactions over %0d register settings",
             items_accepted, settings_used);
    $display("Compared %0d closed segments, %0d mismatches", segments_checked, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
